@@ src/arq_rst_pkg.sv @@
package arq_rst_pkg;

  // Table geometry default
  localparam int SlotCountDef = 256;

  // Field widths
  localparam int REQ_W   = 3;
  localparam int SEQ_W   = 8;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 9;

  // Configuration port
  localparam int                CFG_AW          = 3;
  localparam int                CFG_DW          = 32;
  localparam logic              REG_ACK_TIMEOUT = 1'b0;
  localparam logic [TIME_W-1:0] TimeoutRst      = TIME_W'(200);

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SENT       = 3'd0,
    REQ_ACKED      = 3'd1,
    REQ_NAK        = 3'd2,
    REQ_RETX       = 3'd3,
    REQ_CLEAR_SLOT = 3'd4,
    REQ_POP        = 3'd5,
    REQ_CLEAR_ALL  = 3'd6,
    REQ_COUNT      = 3'd7
  } req_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ld;    // capture request fields
    logic rd;    // read the named slot
    logic upd;   // apply a single-slot request or clear all
    logic scan;  // one step of the expiry scan
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pop_done;  // scan produced its result this cycle
  } dp_sts_t;

endpackage

@@ src/arq_rst_cfg.sv @@
module arq_rst_cfg
  import arq_rst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [TIME_W-1:0] ack_timeout
);

  logic [TIME_W-1:0] timeout_r;
  logic              sel_timeout;

  // Decode the register index from the word address
  assign sel_timeout = (paddr[2] == REG_ACK_TIMEOUT);

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutRst;
    end else if (psel && penable && pwrite && sel_timeout) begin
      timeout_r <= pwdata[TIME_W-1:0];
    end
  end

  assign prdata      = sel_timeout ? CFG_DW'(timeout_r) : '0;
  assign pready      = 1'b1;
  assign ack_timeout = timeout_r;

endmodule

@@ src/arq_rst_ctrl.sv @@
module arq_rst_ctrl
  import arq_rst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  dp_sts_t          sts,
  output dp_cmd_t          cmd,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_SCAN
  } state_t;

  state_t state_r;
  logic   strobe_r;

  // Issue commands for the current state
  always_comb begin
    cmd      = '0;
    cmd.ld   = (state_r == ST_IDLE) && start;
    cmd.rd   = (state_r == ST_READ);
    cmd.upd  = (state_r == ST_UPDATE);
    cmd.scan = (state_r == ST_SCAN);
  end

  // Advance state and raise the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= (req_t'(req_type) == REQ_POP) ? ST_SCAN : ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state_r  <= ST_IDLE;
          strobe_r <= 1'b1;
        end
        ST_SCAN: begin
          if (sts.pop_done) begin
            state_r  <= ST_IDLE;
            strobe_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = strobe_r;

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ($past(state_r) == ST_UPDATE || $past(state_r) == ST_SCAN))
    else $error("result strobe without a finishing step");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE || (state_r == ST_SCAN && sts.pop_done)) |=> strobe_r)
    else $error("finished request gave no result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == ST_IDLE) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

@@ src/arq_rst_dp.sv @@
module arq_rst_dp
  import arq_rst_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [SEQ_W-1:0]   in_seq,
  input  logic [TIME_W-1:0]  in_now_ms,
  input  logic [TIME_W-1:0]  ack_timeout,
  output logic               out_found,
  output logic [SEQ_W-1:0]   out_slot,
  output logic [CNT_W-1:0]   out_retry_count,
  output logic [TOTAL_W-1:0] out_pending_total
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  // Request capture
  req_t              req_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [TIME_W-1:0] now_r;

  // Slot store: flags, counts and stamps in memory, one valid bit per slot in flops
  logic [SLOT_COUNT-1:0] vld_r;
  logic                  pend_mem [SLOT_COUNT];
  logic [CNT_W-1:0]      cnt_mem  [SLOT_COUNT];
  logic [TIME_W-1:0]     time_mem [SLOT_COUNT];
  logic [TOTAL_W-1:0]    tally_r;
  logic [TOTAL_W-1:0]    tally_nxt;

  // Read side
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [CNT_W-1:0]  cnt_rd_r;
  logic [TIME_W-1:0] time_rd_r;
  logic              vld_rd_r;
  logic              pend_rd_r;

  // Scan pipeline
  logic [CW-1:0] scan_idx_r;
  logic          scan_more;
  logic          cand_live_r;
  logic [AW-1:0] cand_idx_r;

  // Update logic
  logic              ok;
  logic              cur_pend;
  logic [CNT_W-1:0]  cur_cnt;
  logic [TIME_W-1:0] cur_time;
  logic [TIME_W-1:0] age;
  logic              hit;
  logic              none;
  logic [AW-1:0]     wr_addr;
  logic              cnt_we;
  logic [CNT_W-1:0]  cnt_wd;
  logic              time_we;
  logic              pend_we;
  logic              pend_wd;
  logic              ent_we;
  logic              pend_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [TIME_W-1:0] time_nxt;
  logic              clr_all;
  logic              res_ld;
  logic              res_found;
  logic [SEQ_W-1:0]  res_slot;
  logic [CNT_W-1:0]  res_cnt;

  // Result registers
  logic               found_r;
  logic [SEQ_W-1:0]   slot_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TOTAL_W-1:0] total_r;

  assign ok        = ({1'b0, seq_r} < (SEQ_W + 1)'(SLOT_COUNT));
  assign scan_more = (scan_idx_r < CW'(SLOT_COUNT));
  assign rd_addr   = cmd.scan ? scan_idx_r[AW-1:0] : seq_r[AW-1:0];
  assign rd_en     = cmd.rd || (cmd.scan && scan_more);

  // Capture the request and step the scan address
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      req_r      <= req_t'(in_req_type);
      seq_r      <= in_seq;
      now_r      <= in_now_ms;
      scan_idx_r <= '0;
    end else if (cmd.scan && scan_more) begin
      scan_idx_r <= scan_idx_r + CW'(1);
    end
    if (cmd.scan) begin
      cand_idx_r <= scan_idx_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_live_r <= 1'b0;
    end else if (cmd.ld) begin
      cand_live_r <= 1'b0;
    end else if (cmd.scan) begin
      cand_live_r <= scan_more;
    end
  end

  // Read and write the slot memories, whole entry at once
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_rd_r <= pend_mem[rd_addr];
      cnt_rd_r  <= cnt_mem[rd_addr];
      time_rd_r <= time_mem[rd_addr];
      vld_rd_r  <= vld_r[rd_addr];
    end
    if (ent_we) begin
      pend_mem[wr_addr] <= pend_nxt;
      cnt_mem[wr_addr]  <= cnt_nxt;
      time_mem[wr_addr] <= time_nxt;
    end
  end

  // Work out the slot update and the result
  always_comb begin
    cur_pend  = vld_rd_r && pend_rd_r;
    cur_cnt   = vld_rd_r ? cnt_rd_r : '0;
    cur_time  = vld_rd_r ? time_rd_r : '0;
    age       = now_r - cur_time;
    hit       = cmd.scan && cand_live_r && cur_pend && (age >= ack_timeout);
    none      = cmd.scan && cand_live_r && !hit && (cand_idx_r == AW'(SLOT_COUNT - 1));
    wr_addr   = seq_r[AW-1:0];
    cnt_we    = 1'b0;
    cnt_wd    = cur_cnt + CNT_W'(1);
    time_we   = 1'b0;
    pend_we   = 1'b0;
    pend_wd   = 1'b0;
    clr_all   = 1'b0;
    res_ld    = 1'b0;
    res_found = 1'b1;
    res_slot  = seq_r;
    res_cnt   = '0;
    if (cmd.upd) begin
      res_ld = 1'b1;
      if (req_r == REQ_CLEAR_ALL) begin
        clr_all = 1'b1;
      end else if (ok) begin
        case (req_r)
          REQ_SENT: begin
            pend_we = 1'b1;
            pend_wd = 1'b1;
            cnt_we  = 1'b1;
            cnt_wd  = '0;
            time_we = 1'b1;
          end
          REQ_ACKED, REQ_CLEAR_SLOT: begin
            pend_we = 1'b1;
            cnt_we  = 1'b1;
            cnt_wd  = '0;
          end
          REQ_NAK: begin
            time_we = cur_pend;
          end
          REQ_RETX: begin
            cnt_we  = 1'b1;
            time_we = 1'b1;
          end
          default: begin
          end
        endcase
        res_cnt = cnt_we ? cnt_wd : cur_cnt;
      end
    end else if (hit) begin
      wr_addr  = cand_idx_r;
      cnt_we   = 1'b1;
      time_we  = 1'b1;
      pend_we  = 1'b1;
      res_ld   = 1'b1;
      res_slot = SEQ_W'(cand_idx_r);
      res_cnt  = cnt_wd;
    end else if (none) begin
      res_ld    = 1'b1;
      res_found = 1'b0;
      res_slot  = '0;
    end

    // Merge the changed fields with the ones read back
    ent_we   = pend_we || cnt_we || time_we;
    pend_nxt = pend_we ? pend_wd : cur_pend;
    cnt_nxt  = cnt_we ? cnt_wd : cur_cnt;
    time_nxt = time_we ? now_r : cur_time;

    // Track the pending tally
    tally_nxt = tally_r;
    if (clr_all) begin
      tally_nxt = '0;
    end else if (pend_we && pend_wd && !cur_pend) begin
      tally_nxt = tally_r + TOTAL_W'(1);
    end else if (pend_we && !pend_wd && cur_pend) begin
      tally_nxt = tally_r - TOTAL_W'(1);
    end
  end

  // Hold valid bits and tally
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      tally_r <= '0;
    end else begin
      tally_r <= tally_nxt;
      if (clr_all) begin
        vld_r <= '0;
      end else if (ent_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Load the result registers
  always_ff @(posedge clk) begin
    if (res_ld) begin
      found_r <= res_found;
      slot_r  <= res_slot;
      cnt_r   <= res_cnt;
      total_r <= tally_nxt;
    end
  end

  assign sts.pop_done      = hit || none;
  assign out_found         = found_r;
  assign out_slot          = slot_r;
  assign out_retry_count   = cnt_r;
  assign out_pending_total = total_r;

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= TOTAL_W'(SLOT_COUNT))
    else $error("pending tally beyond slot count");

  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.upd && !hit) |=> $stable(tally_r))
    else $error("pending tally moved without an update");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> scan_idx_r <= CW'(SLOT_COUNT))
    else $error("scan address ran past the table");

endmodule

@@ src/arq_retransmit_slot_table_core.sv @@
// Flow: a single-slot request, clear all or count is accepted, read in ST_READ and applied
// in ST_UPDATE, and its result is registered; a pop walks the table one slot per cycle and
// answers with the lowest due slot, or with none once the last slot is passed unmatched.
// A new request is taken only in idle; start is ignored while busy with the last one.
// Reset: slots read as empty at once through per-slot valid bits, tally 0; timeout 200.
// Each result is strobed for one cycle on out_valid; the receiver cannot stall.
module arq_retransmit_slot_table_core
  import arq_rst_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [SEQ_W-1:0]   in_seq,
  input  logic [TIME_W-1:0]  in_now_ms,
  output logic               out_valid,
  output logic               out_found,
  output logic [SEQ_W-1:0]   out_slot,
  output logic [CNT_W-1:0]   out_retry_count,
  output logic [TOTAL_W-1:0] out_pending_total,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [TIME_W-1:0] ack_timeout;

  arq_rst_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .ack_timeout (ack_timeout)
  );

  arq_rst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_req_type),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  arq_rst_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_seq            (in_seq),
    .in_now_ms         (in_now_ms),
    .ack_timeout       (ack_timeout),
    .out_found         (out_found),
    .out_slot          (out_slot),
    .out_retry_count   (out_retry_count),
    .out_pending_total (out_pending_total)
  );

endmodule

@@ tb/sv/arq_retransmit_slot_table_core_tb.sv @@
`timescale 1ns / 100ps

module arq_retransmit_slot_table_core_tb;
  import arq_rst_pkg::*;

  localparam int NUM_SLOTS = SlotCountDef;
  localparam logic [CFG_AW-1:0] TIMEOUT_ADDR = CFG_AW'({REG_ACK_TIMEOUT, 2'b00});

  typedef struct packed {
    logic               found;
    logic [SEQ_W-1:0]   slot;
    logic [CNT_W-1:0]   retry_count;
    logic [TOTAL_W-1:0] pending_total;
  } slot_result_t;

  // Shadow of the slot table plus the queue of answers still owed by the block
  class arq_slot_ledger;
    int unsigned       slots;
    logic [TIME_W-1:0] timeout_ms;
    bit                pend[256];
    logic [CNT_W-1:0]  retries[256];
    logic [TIME_W-1:0] stamp[256];
    int unsigned       tally;
    slot_result_t      due_results[$];
    int unsigned       failures;
    int unsigned       checked;
    int unsigned       requests;
    int unsigned       pops_hit;
    int unsigned       pops_empty;

    function new(int unsigned n);
      slots      = n;
      timeout_ms = TimeoutRst;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < 256; i++) begin
        pend[i]    = 1'b0;
        retries[i] = '0;
        stamp[i]   = '0;
      end
      tally = 0;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("%0t ERROR: %s", $realtime, what);
    endfunction

    // Work out the answer to one accepted request and advance the shadow table
    function void apply_request(req_t req, logic [SEQ_W-1:0] seq, logic [TIME_W-1:0] now);
      slot_result_t      res;
      bit                in_range;
      bit                hit;
      logic [TIME_W-1:0] age;
      in_range          = int'(seq) < slots;
      res.found         = 1'b1;
      res.slot          = seq;
      res.retry_count   = '0;
      hit               = 1'b0;
      requests++;
      if (req == REQ_POP) begin
        res.found = 1'b0;
        res.slot  = '0;
        // Take the lowest pending slot whose wrapped age reaches the timeout
        for (int s = 0; s < slots && !hit; s++) begin
          age = now - stamp[s];
          if (pend[s] && age >= timeout_ms) begin
            hit             = 1'b1;
            pend[s]         = 1'b0;
            tally--;
            retries[s]      = retries[s] + 1'b1;
            stamp[s]        = now;
            res.found       = 1'b1;
            res.slot        = SEQ_W'(s);
            res.retry_count = retries[s];
          end
        end
        if (hit) pops_hit++;
        else pops_empty++;
      end else if (req == REQ_CLEAR_ALL) begin
        wipe();
      end else if (in_range) begin
        case (req)
          REQ_SENT: begin
            if (!pend[seq]) tally++;
            pend[seq]    = 1'b1;
            retries[seq] = '0;
            stamp[seq]   = now;
          end
          REQ_ACKED, REQ_CLEAR_SLOT: begin
            // Stamp is left alone on purpose
            if (pend[seq]) tally--;
            pend[seq]    = 1'b0;
            retries[seq] = '0;
          end
          REQ_NAK: begin
            if (pend[seq]) stamp[seq] = now;
          end
          REQ_RETX: begin
            // Applies even to a slot that is not pending; flag stays as is
            retries[seq] = retries[seq] + 1'b1;
            stamp[seq]   = now;
          end
          default: ;
        endcase
      end
      if (req != REQ_POP && in_range) res.retry_count = retries[seq];
      res.pending_total = TOTAL_W'(tally);
      due_results.push_back(res);
    endfunction

    // Compare one strobed result against the oldest outstanding answer
    function void match_result(slot_result_t got);
      slot_result_t exp;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result found=%0d slot=%0d count=%0d total=%0d",
                       got.found, got.slot, got.retry_count, got.pending_total));
        return;
      end
      exp = due_results.pop_front();
      checked++;
      if (got.found !== exp.found || got.slot !== exp.slot ||
          got.retry_count !== exp.retry_count || got.pending_total !== exp.pending_total)
        flag($sformatf({"result mismatch: expected found=%0d slot=%0d count=%0d total=%0d,",
                        " got found=%0d slot=%0d count=%0d total=%0d"},
                       exp.found, exp.slot, exp.retry_count, exp.pending_total,
                       got.found, got.slot, got.retry_count, got.pending_total));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type;
  logic [SEQ_W-1:0]   in_seq;
  logic [TIME_W-1:0]  in_now_ms;
  logic               out_valid;
  logic               out_found;
  logic [SEQ_W-1:0]   out_slot;
  logic [CNT_W-1:0]   out_retry_count;
  logic [TOTAL_W-1:0] out_pending_total;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [CFG_AW-1:0]  paddr;
  logic [CFG_DW-1:0]  pwdata;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  arq_slot_ledger    slot_ledger;
  logic [TIME_W-1:0] cur_time;
  bit                no_gaps;
  int unsigned       timeout_writes;

  arq_retransmit_slot_table_core #(
    .SLOT_COUNT(NUM_SLOTS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_seq           (in_seq),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_slot         (out_slot),
    .out_retry_count  (out_retry_count),
    .out_pending_total(out_pending_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid && slot_ledger != null)
      slot_ledger.match_result('{out_found, out_slot, out_retry_count, out_pending_total});
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one request, hold it until the block takes it, then record it
  task automatic issue(input req_t req, input logic [SEQ_W-1:0] seq,
                       input logic [TIME_W-1:0] now);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type = req;
    in_seq      = seq;
    in_now_ms   = now;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    slot_ledger.apply_request(req, seq, now);
  endtask

  // Drop start and hold off until every owed result is back
  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (slot_ledger.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reprogram the timeout once the block is idle, and read it back
  task automatic set_timeout(input logic [TIME_W-1:0] value);
    logic [CFG_DW-1:0] rd;
    settle();
    apb_access(1'b1, TIMEOUT_ADDR, value, rd);
    slot_ledger.timeout_ms = value;
    timeout_writes++;
    apb_access(1'b0, TIMEOUT_ADDR, '0, rd);
    if (rd !== value)
      slot_ledger.flag($sformatf("timeout readback: expected %0h, got %0h", value, rd));
  endtask

  function automatic req_t pick_req();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return REQ_SENT;
    if (r < 37) return REQ_ACKED;
    if (r < 47) return REQ_NAK;
    if (r < 57) return REQ_RETX;
    if (r < 63) return REQ_CLEAR_SLOT;
    if (r < 88) return REQ_POP;
    if (r < 90) return REQ_CLEAR_ALL;
    return REQ_COUNT;
  endfunction

  // One random request: time mostly moves forward, sometimes steps back or jumps
  task automatic random_request(input int unsigned adv_max);
    logic [TIME_W-1:0] now;
    logic [SEQ_W-1:0]  seq;
    int unsigned       r;
    cur_time = cur_time + $urandom_range(0, adv_max);
    now      = cur_time;
    r        = $urandom_range(0, 99);
    if (r < 5) now = $urandom;
    else if (r < 15) now = cur_time - $urandom_range(1, 3);
    seq = ($urandom_range(0, 99) < 70) ? SEQ_W'($urandom_range(0, 15))
                                       : SEQ_W'($urandom_range(0, 255));
    issue(pick_req(), seq, now);
  endtask

  initial begin
    logic [TIME_W-1:0] phase_timeout[6];
    logic [SEQ_W-1:0]  storm_slot;
    int unsigned       adv_max;

    start          = 1'b0;
    in_req_type    = '0;
    in_seq         = '0;
    in_now_ms      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    rst_n          = 1'b0;
    no_gaps        = 1'b0;
    timeout_writes = 0;
    slot_ledger    = new(NUM_SLOTS);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: boundaries, every request type, timer wrap
    issue(REQ_COUNT, 8'h00, 32'h0000_0000);
    issue(REQ_POP, 8'h00, 32'hFFFF_FFFF);
    issue(REQ_SENT, 8'h00, 32'd1000);
    issue(REQ_SENT, 8'hFF, 32'd1000);
    issue(REQ_NAK, 8'h07, 32'd1100);
    issue(REQ_NAK, 8'h00, 32'd1100);
    issue(REQ_POP, 8'h00, 32'd1299);
    issue(REQ_POP, 8'h00, 32'd1299);
    issue(REQ_POP, 8'h00, 32'd1300);
    issue(REQ_RETX, 8'h09, 32'h8000_0000);
    issue(REQ_RETX, 8'h09, 32'd5);
    issue(REQ_SENT, 8'h09, 32'd10);
    issue(REQ_ACKED, 8'h09, 32'd0);
    issue(REQ_SENT, 8'h0C, 32'hFFFF_FF80);
    issue(REQ_POP, 8'hAA, 32'h0000_0047);
    issue(REQ_POP, 8'h55, 32'h0000_0048);
    issue(REQ_SENT, 8'h1E, 32'd400);
    issue(REQ_SENT, 8'h1F, 32'd400);
    issue(REQ_CLEAR_SLOT, 8'h1E, 32'd401);
    issue(REQ_CLEAR_ALL, 8'h00, 32'd402);
    issue(REQ_COUNT, 8'hFF, 32'hFFFF_FFFF);
    // Largest timeout: only an age of all ones is due
    set_timeout(32'hFFFF_FFFF);
    issue(REQ_SENT, 8'h03, 32'd1000);
    issue(REQ_POP, 8'h00, 32'd1000);
    issue(REQ_POP, 8'h00, 32'd999);
    // Zero timeout: anything pending is due at once
    set_timeout(32'h0000_0000);
    issue(REQ_SENT, 8'h05, 32'd77);
    issue(REQ_POP, 8'h00, 32'd77);

    // Random phases over a spread of timeouts
    phase_timeout[0] = 32'd0;
    phase_timeout[1] = $urandom_range(20, 400);
    phase_timeout[2] = 32'hFFFF_FFFF;
    phase_timeout[3] = 32'h8000_0000;
    phase_timeout[4] = 32'd1;
    phase_timeout[5] = $urandom;
    cur_time         = $urandom;
    for (int p = 0; p < 6; p++) begin
      set_timeout(phase_timeout[p]);
      adv_max = (phase_timeout[p] <= 1000) ? phase_timeout[p] / 2 + 3 : 32'h1000_0000;
      // Walk one slot's count all the way around
      if (p == 1) begin
        storm_slot = SEQ_W'($urandom_range(0, 255));
        issue(REQ_SENT, storm_slot, cur_time);
        for (int i = 0; i < 260; i++) begin
          cur_time = cur_time + $urandom_range(0, 3);
          issue(REQ_RETX, storm_slot, cur_time);
        end
        issue(REQ_ACKED, storm_slot, cur_time);
      end
      for (int i = 0; i < 200; i++) begin
        if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 99) == 0) settle();
        random_request(adv_max);
      end
    end

    // Wait out the tail
    settle();
    repeat (8) @(posedge clk);
    if (slot_ledger.due_results.size() != 0)
      slot_ledger.flag($sformatf("%0d results never arrived", slot_ledger.due_results.size()));

    $display("Run covered %0d requests and %0d checked results over %0d timeout settings;",
             slot_ledger.requests, slot_ledger.checked, timeout_writes);
    $display("pops took a slot %0d times and found none %0d times, %0d failures.",
             slot_ledger.pops_hit, slot_ledger.pops_empty, slot_ledger.failures);
    if (slot_ledger.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
